// ----- hdl/efsd_pkg.sv -----
// ----------------------------------------------------------------------------
// efsd_pkg
// shared types and constants for the earliest free server dispatch block
// ----------------------------------------------------------------------------
package efsd_pkg;

   localparam int ARRIVAL_W = 17;
   localparam int MINUTES_W = 10;
   localparam int SUI_W     = 6;
   localparam int TIME_W    = 32;
   localparam int TOTAL_W   = 48;
   localparam int COUNT_W   = 20;
   localparam int IDX_OUT_W = 5;
   localparam int SVC_SEC_W = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 17;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SERVERS_IN_USE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TIME      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_TIME     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_CAP    = 8'd3;

   localparam logic [SUI_W-1:0]     SUI_RESET   = 6'd1;
   localparam logic [ARRIVAL_W-1:0] OPEN_RESET  = 17'd28800;
   localparam logic [ARRIVAL_W-1:0] CLOSE_RESET = 17'd61200;
   localparam logic [MINUTES_W-1:0] CAP_RESET   = 10'd60;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture item at accept
      logic scan;      // issue one free time read
      logic calc;      // form start and wait
      logic commit;    // write back free time, bump totals
      logic out_load;  // load the result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic reject;     // incoming item arrives after close
      logic scan_last;  // current read is the last active server
      logic out_free;   // result register can take a new item
   } sts_type;

endpackage

// ----- hdl/efsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// efsd_ctrl
// sequencer: accept, scan servers, compute start, commit, hand off result
// ----------------------------------------------------------------------------
module efsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  efsd_pkg::sts_type sts,
   output efsd_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_LAST   = 3'd2;
   localparam logic [2:0] ST_CALC   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.reject ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_LAST;
            end
         end
         // last read data is compared here
         ST_LAST: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/efsd_dp.sv -----
// ----------------------------------------------------------------------------
// efsd_dp
// datapath: registers, free time memory, min scan, totals, result register
// ----------------------------------------------------------------------------
module efsd_dp #(
   parameter int SERVERS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  efsd_pkg::cmd_type                   cmd,
   output efsd_pkg::sts_type                   sts,
   input  logic [efsd_pkg::ARRIVAL_W-1:0]      req_arrival_seconds,
   input  logic [efsd_pkg::MINUTES_W-1:0]      req_service_minutes,
   input  logic                                csr_valid,
   input  logic [efsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [efsd_pkg::CSR_DAT_W-1:0]      csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_served,
   output logic [efsd_pkg::IDX_OUT_W-1:0]      rsp_server_index,
   output logic [efsd_pkg::TIME_W-1:0]         rsp_start_seconds,
   output logic [efsd_pkg::TIME_W-1:0]         rsp_wait_seconds,
   output logic [efsd_pkg::TOTAL_W-1:0]        rsp_total_wait_seconds,
   output logic [efsd_pkg::COUNT_W-1:0]        rsp_served_count
);

   localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;

   // configuration
   logic [efsd_pkg::SUI_W-1:0]     sui_ff;
   logic [efsd_pkg::ARRIVAL_W-1:0] open_ff;
   logic [efsd_pkg::ARRIVAL_W-1:0] close_ff;
   logic [efsd_pkg::MINUTES_W-1:0] cap_ff;
   logic                           open_wr;

   assign open_wr = csr_valid && (csr_index == efsd_pkg::CSR_OPEN_TIME);

   always_ff @(posedge clock) begin
      if (reset) begin
         sui_ff   <= efsd_pkg::SUI_RESET;
         open_ff  <= efsd_pkg::OPEN_RESET;
         close_ff <= efsd_pkg::CLOSE_RESET;
         cap_ff   <= efsd_pkg::CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            efsd_pkg::CSR_SERVERS_IN_USE: sui_ff   <= csr_data[efsd_pkg::SUI_W-1:0];
            efsd_pkg::CSR_OPEN_TIME:      open_ff  <= csr_data;
            efsd_pkg::CSR_CLOSE_TIME:     close_ff <= csr_data;
            efsd_pkg::CSR_SERVICE_CAP:    cap_ff   <= csr_data[efsd_pkg::MINUTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // last active server index
   logic [7:0]    sui_w;
   logic [IW-1:0] last_idx;

   assign sui_w = {2'b00, sui_ff};

   always_comb begin
      if (sui_w == 8'd0) begin
         last_idx = '0;
      end else if (sui_w > 8'(SERVERS)) begin
         last_idx = IW'(SERVERS - 1);
      end else begin
         last_idx = IW'(sui_w - 8'd1);
      end
   end

   // item capture
   logic [efsd_pkg::ARRIVAL_W-1:0] arrival_ff;
   logic [efsd_pkg::SVC_SEC_W-1:0] svc_sec_ff;
   logic                           served_ff;
   logic [efsd_pkg::MINUTES_W-1:0] min_clip;

   assign min_clip   = (req_service_minutes > cap_ff) ? cap_ff : req_service_minutes;
   assign sts.reject = (req_arrival_seconds > close_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arrival_ff <= req_arrival_seconds;
         svc_sec_ff <= efsd_pkg::SVC_SEC_W'(min_clip)
                     * efsd_pkg::SVC_SEC_W'(efsd_pkg::SECONDS_PER_MINUTE);
         served_ff  <= !sts.reject;
      end
   end

   // free time memory; an entry not written since open time reload reads as open time
   logic [efsd_pkg::TIME_W-1:0] mem [SERVERS];
   logic [SERVERS-1:0]          vld_ff;
   logic [IW-1:0]               idx_ff;
   logic [efsd_pkg::TIME_W-1:0] rdata_ff;
   logic                        rvld_ff;
   logic [IW-1:0]               ridx_ff;
   logic                        cmp_ff;
   logic [efsd_pkg::TIME_W-1:0] rd_eff;
   logic [efsd_pkg::TIME_W-1:0] best_ff;
   logic [IW-1:0]               best_idx_ff;
   logic [efsd_pkg::TIME_W-1:0] end_time;
   logic [efsd_pkg::TIME_W:0]   end_sum;

   assign sts.scan_last = (idx_ff == last_idx);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[idx_ff];
      rvld_ff  <= vld_ff[idx_ff];
      ridx_ff  <= idx_ff;
      if (cmd.commit) begin
         mem[best_idx_ff] <= end_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || open_wr) begin
         vld_ff <= '0;
      end else if (cmd.commit) begin
         vld_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff <= 1'b0;
      end else begin
         cmp_ff <= cmd.scan;
      end
   end

   assign rd_eff = rvld_ff ? rdata_ff : efsd_pkg::TIME_W'(open_ff);

   // running minimum, strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (cmp_ff && ((ridx_ff == '0) || (rd_eff < best_ff))) begin
         best_ff     <= rd_eff;
         best_idx_ff <= ridx_ff;
      end
   end

   // start and wait
   logic [efsd_pkg::TIME_W-1:0] start_ff;
   logic [efsd_pkg::TIME_W-1:0] wait_ff;
   logic [efsd_pkg::TIME_W-1:0] arr_w;

   assign arr_w = efsd_pkg::TIME_W'(arrival_ff);

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         if (best_ff > arr_w) begin
            start_ff <= best_ff;
            wait_ff  <= best_ff - arr_w;
         end else begin
            start_ff <= arr_w;
            wait_ff  <= '0;
         end
      end
   end

   assign end_sum  = {1'b0, start_ff} + (efsd_pkg::TIME_W + 1)'(svc_sec_ff);
   assign end_time = end_sum[efsd_pkg::TIME_W] ? efsd_pkg::TIME_MAX
                                               : end_sum[efsd_pkg::TIME_W-1:0];

   // running totals
   logic [efsd_pkg::TOTAL_W-1:0] total_ff;
   logic [efsd_pkg::COUNT_W-1:0] count_ff;
   logic [efsd_pkg::TOTAL_W:0]   total_sum;

   assign total_sum = {1'b0, total_ff} + (efsd_pkg::TOTAL_W + 1)'(wait_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         total_ff <= total_sum[efsd_pkg::TOTAL_W] ? efsd_pkg::TOTAL_MAX
                                                  : total_sum[efsd_pkg::TOTAL_W-1:0];
         if (count_ff != efsd_pkg::COUNT_MAX) begin
            count_ff <= count_ff + efsd_pkg::COUNT_W'(1);
         end
      end
   end

   // result register
   logic rsp_valid_ff;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_served             <= served_ff;
         rsp_server_index       <= served_ff ? efsd_pkg::IDX_OUT_W'(best_idx_ff) : '0;
         rsp_start_seconds      <= served_ff ? start_ff : '0;
         rsp_wait_seconds       <= served_ff ? wait_ff : '0;
         rsp_total_wait_seconds <= total_ff;
         rsp_served_count       <= count_ff;
      end
   end

endmodule

// ----- hdl/earliest_free_server_dispatch.sv -----
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch
// dispatches each job to the active server that becomes free first
// ----------------------------------------------------------------------------
// one item on the req channel is a job (arrival second, service minutes);
// one item comes back on the rsp channel for every job, in order.
// a job arriving after close time is returned with served low and leaves
// the free times, wait total and served count unchanged; it skips the
// scan, and the next job is taken once its result is loaded.
// a served job scans the free time memory one server per cycle through its
// single read port, then passes the last compare, start and commit states
// before its result is loaded and the next job is taken, so the time per
// job grows with the number of active servers.
// req_stall is high while a job is in work. the result sits in an output
// register, so the next job is accepted while rsp_stall holds a result;
// the sequencer only waits if a second result is ready before the first
// has been taken. csr writes are always ready and belong between jobs;
// writing open time makes every server free at that second again.
// reset restores the register defaults, sets all servers free at open
// time and clears the wait total and served count, with no clearing pass.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch #(
   parameter int SERVERS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [efsd_pkg::ARRIVAL_W-1:0]      req_arrival_seconds,
   input  logic [efsd_pkg::MINUTES_W-1:0]      req_service_minutes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_served,
   output logic [efsd_pkg::IDX_OUT_W-1:0]      rsp_server_index,
   output logic [efsd_pkg::TIME_W-1:0]         rsp_start_seconds,
   output logic [efsd_pkg::TIME_W-1:0]         rsp_wait_seconds,
   output logic [efsd_pkg::TOTAL_W-1:0]        rsp_total_wait_seconds,
   output logic [efsd_pkg::COUNT_W-1:0]        rsp_served_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [efsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [efsd_pkg::CSR_DAT_W-1:0]      csr_data
);

   efsd_pkg::cmd_type cmd;
   efsd_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   efsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   efsd_dp #(
      .SERVERS (SERVERS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_arrival_seconds    (req_arrival_seconds),
      .req_service_minutes    (req_service_minutes),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_served             (rsp_served),
      .rsp_server_index       (rsp_server_index),
      .rsp_start_seconds      (rsp_start_seconds),
      .rsp_wait_seconds       (rsp_wait_seconds),
      .rsp_total_wait_seconds (rsp_total_wait_seconds),
      .rsp_served_count       (rsp_served_count)
   );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for earliest_free_server_dispatch
// ----------------------------------------------------------------------------
// jobs go in on the req channel and are mirrored by a local dispatcher model
// that keeps its own free times, wait total and served count. every result
// on the rsp channel is compared field by field with the oldest prediction.
// directed tests cover the register defaults, server choice and tie break,
// the odd register settings and ignored indexes, then a backpressure burst,
// random traffic with register changes between phases, and a run of
// full-length jobs on one server that builds up long waits.
// ----------------------------------------------------------------------------
module tb;

   localparam int          SERVER_SLOTS  = 32;
   localparam int          RANDOM_ITEMS  = 1750;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_CYCLES  = 64;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          LONG_JOBS     = 24;
   localparam int unsigned CYCLE_LIMIT   = 4000000;
   localparam logic [efsd_pkg::ARRIVAL_W-1:0] ARRIVAL_TOP = '1;
   localparam logic [efsd_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 8'd4;
   localparam logic [efsd_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 8'hFF;

   typedef struct packed {
      logic                           served;
      logic [efsd_pkg::IDX_OUT_W-1:0] server_index;
      logic [efsd_pkg::TIME_W-1:0]    start_sec;
      logic [efsd_pkg::TIME_W-1:0]    wait_sec;
      logic [efsd_pkg::TOTAL_W-1:0]   total_wait;
      logic [efsd_pkg::COUNT_W-1:0]   served_cnt;
   } dispatch_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [efsd_pkg::ARRIVAL_W-1:0] req_arrival_seconds = '0;
   logic [efsd_pkg::MINUTES_W-1:0] req_service_minutes = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_served;
   logic [efsd_pkg::IDX_OUT_W-1:0] rsp_server_index;
   logic [efsd_pkg::TIME_W-1:0]    rsp_start_seconds;
   logic [efsd_pkg::TIME_W-1:0]    rsp_wait_seconds;
   logic [efsd_pkg::TOTAL_W-1:0]   rsp_total_wait_seconds;
   logic [efsd_pkg::COUNT_W-1:0]   rsp_served_count;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [efsd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [efsd_pkg::CSR_DAT_W-1:0] csr_data = '0;

   // dispatcher model state
   logic [efsd_pkg::SUI_W-1:0]     cfg_servers;
   logic [efsd_pkg::ARRIVAL_W-1:0] cfg_open;
   logic [efsd_pkg::ARRIVAL_W-1:0] cfg_close;
   logic [efsd_pkg::MINUTES_W-1:0] cfg_cap;
   logic [efsd_pkg::TIME_W-1:0]    free_at [SERVER_SLOTS];
   logic [efsd_pkg::TOTAL_W-1:0]   wait_sum;
   logic [efsd_pkg::COUNT_W-1:0]   job_total;

   dispatch_type pending_results[$];
   int           mismatches = 0;
   int           hold_left = 0;
   bit           quiet = 1'b0;
   int unsigned  cycle_count = 0;

   earliest_free_server_dispatch #(
      .SERVERS(SERVER_SLOTS)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_arrival_seconds    (req_arrival_seconds),
      .req_service_minutes    (req_service_minutes),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_served             (rsp_served),
      .rsp_server_index       (rsp_server_index),
      .rsp_start_seconds      (rsp_start_seconds),
      .rsp_wait_seconds       (rsp_wait_seconds),
      .rsp_total_wait_seconds (rsp_total_wait_seconds),
      .rsp_served_count       (rsp_served_count),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = !quiet && ($urandom_range(99) < 27);
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      dispatch_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, expected none actual start %0d", $time,
                     rsp_start_seconds);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("served", want.served, rsp_served);
            check_field("server_index", want.server_index, rsp_server_index);
            check_field("start_seconds", want.start_sec, rsp_start_seconds);
            check_field("wait_seconds", want.wait_sec, rsp_wait_seconds);
            check_field("total_wait_seconds", want.total_wait, rsp_total_wait_seconds);
            check_field("served_count", want.served_cnt, rsp_served_count);
         end
      end
   end

   // picks the earliest free active server and advances the model
   function automatic dispatch_type dispatch_job(logic [efsd_pkg::ARRIVAL_W-1:0] arr,
                                                 logic [efsd_pkg::MINUTES_W-1:0] mins);
      dispatch_type                   r;
      logic [efsd_pkg::MINUTES_W-1:0] billed;
      logic [efsd_pkg::TIME_W-1:0]    best_t;
      logic [efsd_pkg::TIME_W-1:0]    start_t;
      logic [63:0]                    finish;
      logic [efsd_pkg::TOTAL_W:0]     sum;
      int                             active;
      int                             best;
      int                             j;
      r = '0;
      if (arr > cfg_close) begin
         r.total_wait = wait_sum;
         r.served_cnt = job_total;
         return r;
      end
      billed = (mins > cfg_cap) ? cfg_cap : mins;
      active = (cfg_servers == 0) ? 1 : int'(cfg_servers);
      if (active > SERVER_SLOTS)
         active = SERVER_SLOTS;
      best = 0;
      best_t = free_at[0];
      for (j = 1; j < active; j++) begin
         if (free_at[j] < best_t) begin
            best_t = free_at[j];
            best = j;
         end
      end
      start_t = (best_t > efsd_pkg::TIME_W'(arr)) ? best_t : efsd_pkg::TIME_W'(arr);
      finish = 64'(start_t) + 64'(billed) * 64'(efsd_pkg::SECONDS_PER_MINUTE);
      free_at[best] = (finish > 64'(efsd_pkg::TIME_MAX)) ? efsd_pkg::TIME_MAX
                                                         : finish[efsd_pkg::TIME_W-1:0];
      sum = (efsd_pkg::TOTAL_W+1)'(wait_sum)
          + (efsd_pkg::TOTAL_W+1)'(start_t - efsd_pkg::TIME_W'(arr));
      wait_sum = sum[efsd_pkg::TOTAL_W] ? efsd_pkg::TOTAL_MAX : sum[efsd_pkg::TOTAL_W-1:0];
      if (job_total != efsd_pkg::COUNT_MAX)
         job_total++;
      r.served = 1'b1;
      r.server_index = efsd_pkg::IDX_OUT_W'(best);
      r.start_sec = start_t;
      r.wait_sec = start_t - efsd_pkg::TIME_W'(arr);
      r.total_wait = wait_sum;
      r.served_cnt = job_total;
      return r;
   endfunction

   // called and returns at a falling edge
   task automatic send_job(logic [efsd_pkg::ARRIVAL_W-1:0] arr,
                           logic [efsd_pkg::MINUTES_W-1:0] mins);
      int gap;
      if (!quiet && $urandom_range(99) < 27) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, ($urandom_range(9) == 0) ? 40 : 4);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_arrival_seconds = arr;
      req_service_minutes = mins;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), dispatch_job(arr, mins));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic program_register(logic [efsd_pkg::CSR_IDX_W-1:0] idx,
                                   logic [efsd_pkg::CSR_DAT_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         efsd_pkg::CSR_SERVERS_IN_USE: cfg_servers = data[efsd_pkg::SUI_W-1:0];
         efsd_pkg::CSR_OPEN_TIME: begin
            cfg_open = data[efsd_pkg::ARRIVAL_W-1:0];
            foreach (free_at[i]) free_at[i] = efsd_pkg::TIME_W'(cfg_open);
         end
         efsd_pkg::CSR_CLOSE_TIME:     cfg_close = data[efsd_pkg::ARRIVAL_W-1:0];
         efsd_pkg::CSR_SERVICE_CAP:    cfg_cap = data[efsd_pkg::MINUTES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_until_idle();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_job('0, '0);
      send_job(efsd_pkg::ARRIVAL_W'(61200), '1);
      send_job(efsd_pkg::ARRIVAL_W'(61201), efsd_pkg::MINUTES_W'(5));
      send_job(ARRIVAL_TOP, '1);
   endtask

   task automatic test_server_choice();
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(4));
      program_register(efsd_pkg::CSR_OPEN_TIME, efsd_pkg::CSR_DAT_W'(1000));
      program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(1023));
      // all four tie at open time, so they fill in index order
      send_job(efsd_pkg::ARRIVAL_W'(1000), efsd_pkg::MINUTES_W'(10));
      send_job(efsd_pkg::ARRIVAL_W'(1000), efsd_pkg::MINUTES_W'(5));
      send_job(efsd_pkg::ARRIVAL_W'(1000), efsd_pkg::MINUTES_W'(20));
      send_job(efsd_pkg::ARRIVAL_W'(1000), efsd_pkg::MINUTES_W'(1));
      send_job(efsd_pkg::ARRIVAL_W'(1000), efsd_pkg::MINUTES_W'(1));
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(2));
      send_job(efsd_pkg::ARRIVAL_W'(1100), efsd_pkg::MINUTES_W'(3));
      wait_until_idle();
      // zero behaves as one server
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(0));
      send_job(efsd_pkg::ARRIVAL_W'(1200), efsd_pkg::MINUTES_W'(0));
      wait_until_idle();
      // above the server count clamps, idle servers kept their free times
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(63));
      send_job(efsd_pkg::ARRIVAL_W'(1200), efsd_pkg::MINUTES_W'(7));
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, {11'h7FF, 6'd32});
      send_job(efsd_pkg::ARRIVAL_W'(1200), efsd_pkg::MINUTES_W'(2));
   endtask

   task automatic test_special_configs();
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(0));
      send_job(efsd_pkg::ARRIVAL_W'(1300), efsd_pkg::MINUTES_W'(500));
      wait_until_idle();
      program_register(CSR_UNUSED_LOW, '1);
      program_register(CSR_UNUSED_HIGH, '0);
      send_job(efsd_pkg::ARRIVAL_W'(1300), efsd_pkg::MINUTES_W'(1));
      // arrivals going backwards are dispatched as given
      send_job(efsd_pkg::ARRIVAL_W'(500), efsd_pkg::MINUTES_W'(3));
      send_job('0, efsd_pkg::MINUTES_W'(1));
      wait_until_idle();
      program_register(efsd_pkg::CSR_CLOSE_TIME, '0);
      send_job('0, efsd_pkg::MINUTES_W'(9));
      send_job(efsd_pkg::ARRIVAL_W'(1), efsd_pkg::MINUTES_W'(9));
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(1023));
      program_register(efsd_pkg::CSR_CLOSE_TIME, efsd_pkg::CSR_DAT_W'(ARRIVAL_TOP));
      program_register(efsd_pkg::CSR_OPEN_TIME, efsd_pkg::CSR_DAT_W'(ARRIVAL_TOP));
      send_job('0, '1);
      send_job(ARRIVAL_TOP, efsd_pkg::MINUTES_W'(1023));
   endtask

   task automatic test_backpressure();
      int arr;
      wait_until_idle();
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(4));
      program_register(efsd_pkg::CSR_OPEN_TIME, '0);
      program_register(efsd_pkg::CSR_CLOSE_TIME, efsd_pkg::CSR_DAT_W'(86399));
      program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(50));
      hold_left = HOLD_CYCLES;
      arr = 0;
      repeat (12) begin
         arr = arr + $urandom_range(0, 40);
         send_job(efsd_pkg::ARRIVAL_W'(arr), efsd_pkg::MINUTES_W'($urandom_range(0, 80)));
      end
   endtask

   task automatic test_random_traffic();
      int                             sent;
      int                             arr;
      int                             step_max;
      int                             burst;
      int                             span;
      logic [efsd_pkg::SUI_W-1:0]     servers;
      logic [efsd_pkg::ARRIVAL_W-1:0] bound;
      logic [efsd_pkg::MINUTES_W-1:0] mins;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_until_idle();
         quiet = ($urandom_range(9) == 0);
         case ($urandom_range(7))
            0:       servers = 6'd0;
            1:       servers = 6'd63;
            2:       servers = 6'd32;
            3:       servers = 6'd1;
            default: servers = efsd_pkg::SUI_W'($urandom_range(2, 31));
         endcase
         program_register(efsd_pkg::CSR_SERVERS_IN_USE, {11'($urandom), servers});
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(9))
               0:       bound = '0;
               1:       bound = ARRIVAL_TOP;
               default: bound = efsd_pkg::ARRIVAL_W'($urandom_range(0, 86399));
            endcase
            program_register(efsd_pkg::CSR_OPEN_TIME, bound);
         end
         case ($urandom_range(9))
            0:       bound = '0;
            1:       bound = ARRIVAL_TOP;
            default: begin
               arr = int'(cfg_open) + $urandom_range(600, 30000);
               bound = (arr > int'(ARRIVAL_TOP)) ? ARRIVAL_TOP : efsd_pkg::ARRIVAL_W'(arr);
            end
         endcase
         program_register(efsd_pkg::CSR_CLOSE_TIME, bound);
         case ($urandom_range(9))
            0:       span = 0;
            1:       span = 1023;
            2:       span = $urandom_range(0, 1023);
            default: span = $urandom_range(1, 90);
         endcase
         program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(span));
         // start a little before open so early jobs queue on the open time
         arr = (cfg_open > 300) ? int'(cfg_open) - int'($urandom_range(0, 300)) : 0;
         burst = $urandom_range(10, 60);
         step_max = $urandom_range(1) ? 30 : 400;
         span = int'(cfg_cap);
         span = span + span / 4 + 1;
         if (span > 1023)
            span = 1023;
         repeat (burst) begin
            if ($urandom_range(9) == 0)
               mins = efsd_pkg::MINUTES_W'($urandom);
            else
               mins = efsd_pkg::MINUTES_W'($urandom_range(0, span));
            case ($urandom_range(19))
               0: send_job(efsd_pkg::ARRIVAL_W'($urandom), mins);
               1: send_job((arr > 500) ?
                           efsd_pkg::ARRIVAL_W'(arr - int'($urandom_range(1, 500))) : '0,
                           mins);
               default: begin
                  arr = arr + $urandom_range(0, step_max);
                  if (arr > int'(ARRIVAL_TOP))
                     arr = int'(ARRIVAL_TOP);
                  send_job(efsd_pkg::ARRIVAL_W'(arr), mins);
               end
            endcase
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // one server, full-length jobs at second zero: each job waits for all
   // the ones before it, so waits and the wait total climb quickly
   task automatic test_long_waits();
      wait_until_idle();
      quiet = 1'b1;
      program_register(efsd_pkg::CSR_SERVERS_IN_USE, efsd_pkg::CSR_DAT_W'(1));
      program_register(efsd_pkg::CSR_OPEN_TIME, '0);
      program_register(efsd_pkg::CSR_CLOSE_TIME, efsd_pkg::CSR_DAT_W'(ARRIVAL_TOP));
      program_register(efsd_pkg::CSR_SERVICE_CAP, efsd_pkg::CSR_DAT_W'(1023));
      repeat (LONG_JOBS) send_job('0, '1);
      quiet = 1'b0;
   endtask

   initial begin
      cfg_servers = efsd_pkg::SUI_RESET;
      cfg_open = efsd_pkg::OPEN_RESET;
      cfg_close = efsd_pkg::CLOSE_RESET;
      cfg_cap = efsd_pkg::CAP_RESET;
      foreach (free_at[i]) free_at[i] = efsd_pkg::TIME_W'(efsd_pkg::OPEN_RESET);
      wait_sum = '0;
      job_total = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_server_choice();
      test_special_configs();
      test_backpressure();
      test_random_traffic();
      test_long_waits();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
